@@ design/pns_pkg.sv @@
// ----------------------------------------------------------------------------
// pns_pkg
// types and sizes used by the priority scheduler, including the job record kept in its job ram
// ----------------------------------------------------------------------------
package pns_pkg;

   localparam int MAX_JOBS = 16;
   localparam int IDX_W    = $clog2(MAX_JOBS);
   localparam int CNT_W    = $clog2(MAX_JOBS + 1);
   localparam int TIME_W   = 21;
   localparam int TOTAL_W  = 25;

   typedef struct packed {
      logic [15:0] arrival_time;
      logic [15:0] burst_length;
      logic [7:0]  job_priority;
      logic        final_job;
   } req_type;

   typedef struct packed {
      logic [3:0]         job_index;
      logic [TIME_W-1:0]  finish_time;
      logic [TIME_W-1:0]  turnaround;
      logic [TIME_W-1:0]  wait_time;
      logic [TOTAL_W-1:0] sum_wait;
      logic [TOTAL_W-1:0] sum_turnaround;
      logic               run_done;
   } rsp_type;

   typedef struct packed {
      logic [15:0] arrival;
      logic [15:0] burst;
      logic [7:0]  priority_num;
   } job_type;

endpackage

@@ design/pns_ram.sv @@
// ----------------------------------------------------------------------------
// pns_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module pns_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/priority_nonpreemptive_scheduler.sv @@
// ----------------------------------------------------------------------------
// priority_nonpreemptive_scheduler
// loads a job set into a ram, then runs it non-preemptively by priority
// ----------------------------------------------------------------------------
// loading: one item per cycle, busy stays low until the final item is taken
// each result takes one ram scan of job_count reads, then the drain, decide, advance,
//    turnaround and report states; a scan that finds no ready job jumps the clock to the next arrival and scans again
// results are never held off: rsp_strobe is high for one cycle per item
// synchronous reset clears the job count, finished flags, clock and totals;
//    the job ram itself is not cleared, only loaded entries are read
module priority_nonpreemptive_scheduler
   import pns_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DRAIN  = 3'd2;
   localparam logic [2:0] ST_DECIDE = 3'd3;
   localparam logic [2:0] ST_ADV    = 3'd4;
   localparam logic [2:0] ST_TURN   = 3'd5;
   localparam logic [2:0] ST_REPORT = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    done_ff, done_in;
   logic [MAX_JOBS-1:0] fin_ff, fin_in;
   logic [TIME_W-1:0]   clock_ff, clock_in;
   logic [TOTAL_W-1:0]  wait_total_ff, wait_total_in;
   logic [TOTAL_W-1:0]  turn_total_ff, turn_total_in;
   logic [IDX_W-1:0]    scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                rd_pend_ff, rd_pend_in;
   logic                found_ff, found_in;
   logic                any_ff, any_in;
   logic [7:0]          best_pri_ff, best_pri_in;
   logic [15:0]         best_arr_ff, best_arr_in;
   logic [15:0]         best_burst_ff, best_burst_in;
   logic [IDX_W-1:0]    pick_ff, pick_in;
   logic [15:0]         next_arr_ff, next_arr_in;
   logic [TIME_W-1:0]   turn_ff, turn_in;
   rsp_type             rsp_ff, rsp_in;
   logic                strobe_ff, strobe_in;

   logic                accept;
   logic                wr_en;
   job_type             wr_job;
   job_type             rd_job;
   logic [CNT_W-1:0]    last_cnt;
   logic [TIME_W-1:0]   wait_val;
   logic [TOTAL_W-1:0]  wait_sum;
   logic [TOTAL_W-1:0]  turn_sum;
   logic                rd_open;

   pns_ram #(
      .WIDTH ($bits(job_type)),
      .DEPTH (MAX_JOBS)
   ) u_job_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_job),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_job)
   );

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign wr_en    = accept && (count_ff < CNT_W'(MAX_JOBS));
   assign last_cnt = count_ff - CNT_W'(1);
   assign rd_open  = !fin_ff[rd_idx_ff];

   always_comb begin
      wr_job.arrival      = req_item.arrival_time;
      wr_job.burst        = req_item.burst_length;
      wr_job.priority_num = req_item.job_priority;
   end

   assign wait_val = turn_ff - TIME_W'(best_burst_ff);
   assign wait_sum = wait_total_ff + TOTAL_W'(wait_val);
   assign turn_sum = turn_total_ff + TOTAL_W'(turn_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      done_in       = done_ff;
      fin_in        = fin_ff;
      clock_in      = clock_ff;
      wait_total_in = wait_total_ff;
      turn_total_in = turn_total_ff;
      scan_idx_in   = scan_idx_ff;
      rd_idx_in     = scan_idx_ff;
      rd_pend_in    = (state_ff == ST_SCAN);
      found_in      = found_ff;
      any_in        = any_ff;
      best_pri_in   = best_pri_ff;
      best_arr_in   = best_arr_ff;
      best_burst_in = best_burst_ff;
      pick_in       = pick_ff;
      next_arr_in   = next_arr_ff;
      turn_in       = turn_ff;
      rsp_in        = rsp_ff;
      strobe_in     = 1'b0;

      // compare the job read last cycle against the running choice
      if (rd_pend_ff && rd_open) begin
         if ((TIME_W'(rd_job.arrival) <= clock_ff) &&
             (!found_ff || (rd_job.priority_num < best_pri_ff))) begin
            found_in      = 1'b1;
            best_pri_in   = rd_job.priority_num;
            best_arr_in   = rd_job.arrival;
            best_burst_in = rd_job.burst;
            pick_in       = rd_idx_ff;
         end
         if (!any_ff || (rd_job.arrival < next_arr_ff)) begin
            any_in      = 1'b1;
            next_arr_in = rd_job.arrival;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (wr_en) begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_item.final_job) begin
                  state_in    = ST_SCAN;
                  scan_idx_in = '0;
                  found_in    = 1'b0;
                  any_in      = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            if ({{(CNT_W-IDX_W){1'b0}}, scan_idx_ff} == last_cnt) begin
               state_in = ST_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (found_ff) begin
               state_in = ST_ADV;
            end else begin
               // nothing ready: jump to the earliest pending arrival
               clock_in    = TIME_W'(next_arr_ff);
               state_in    = ST_SCAN;
               scan_idx_in = '0;
               found_in    = 1'b0;
               any_in      = 1'b0;
            end
         end
         ST_ADV: begin
            clock_in = clock_ff + TIME_W'(best_burst_ff);
            state_in = ST_TURN;
         end
         ST_TURN: begin
            turn_in  = clock_ff - TIME_W'(best_arr_ff);
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            rsp_in.job_index      = 4'(pick_ff);
            rsp_in.finish_time    = clock_ff;
            rsp_in.turnaround     = turn_ff;
            rsp_in.wait_time      = wait_val;
            rsp_in.sum_wait       = wait_sum;
            rsp_in.sum_turnaround = turn_sum;
            rsp_in.run_done       = (done_ff == last_cnt);
            strobe_in             = 1'b1;
            if (done_ff == last_cnt) begin
               // end of run: clear the set
               state_in      = ST_IDLE;
               count_in      = '0;
               done_in       = '0;
               fin_in        = '0;
               clock_in      = '0;
               wait_total_in = '0;
               turn_total_in = '0;
            end else begin
               state_in            = ST_SCAN;
               done_in             = done_ff + CNT_W'(1);
               fin_in[pick_ff]     = 1'b1;
               wait_total_in       = wait_sum;
               turn_total_in       = turn_sum;
               scan_idx_in         = '0;
               found_in            = 1'b0;
               any_in              = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         done_ff       <= '0;
         fin_ff        <= '0;
         clock_ff      <= '0;
         wait_total_ff <= '0;
         turn_total_ff <= '0;
         rd_pend_ff    <= 1'b0;
         found_ff      <= 1'b0;
         any_ff        <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         done_ff       <= done_in;
         fin_ff        <= fin_in;
         clock_ff      <= clock_in;
         wait_total_ff <= wait_total_in;
         turn_total_ff <= turn_total_in;
         rd_pend_ff    <= rd_pend_in;
         found_ff      <= found_in;
         any_ff        <= any_in;
         strobe_ff     <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff   <= scan_idx_in;
      rd_idx_ff     <= rd_idx_in;
      best_pri_ff   <= best_pri_in;
      best_arr_ff   <= best_arr_in;
      best_burst_ff <= best_burst_in;
      pick_ff       <= pick_in;
      next_arr_ff   <= next_arr_in;
      turn_ff       <= turn_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule
